@@ rtl/mmc_pkg.sv @@
package mmc_pkg;

    // Result field width (signed Q.4).
    localparam int OUT_W = 23;

    // Largest scale ratio; a ratio saturates here.
    localparam int RATIO_MAX = 65535;

    // Default extremes that capture items widen from.
    localparam int XMIN_DEF = -619;
    localparam int XMAX_DEF = 648;
    localparam int YMIN_DEF = -338;
    localparam int YMAX_DEF = 613;
    localparam int ZMIN_DEF = -443;
    localparam int ZMAX_DEF = 651;

    // Item kinds.
    localparam logic [1:0] KIND_CAPTURE  = 2'd0;
    localparam logic [1:0] KIND_FINALIZE = 2'd1;
    localparam logic [1:0] KIND_MEASURE  = 2'd2;

    // Axis selects for the shared multiplier.
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_CAPT = 8'b0000_0010,
        S_FIN  = 8'b0000_0100,
        S_DIVY = 8'b0000_1000,
        S_DIVZ = 8'b0001_0000,
        S_MUL  = 8'b0010_0000,
        S_ACC  = 8'b0100_0000,
        S_WB   = 8'b1000_0000
    } state_t;

    // Status that the divider reports to the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

@@ rtl/mmc_in_if.sv @@
interface mmc_in_if #(
    parameter int SAMPLE_BITS = 13
) ();
    logic                          valid;
    logic                          ready;
    logic [1:0]                    kind;
    logic signed [SAMPLE_BITS-1:0] axis_x;
    logic signed [SAMPLE_BITS-1:0] axis_y;
    logic signed [SAMPLE_BITS-1:0] axis_z;

    modport source (output valid, output kind, output axis_x, output axis_y,
                    output axis_z, input ready);
    modport sink (input valid, input kind, input axis_x, input axis_y,
                  input axis_z, output ready);
endinterface

@@ rtl/mmc_out_if.sv @@
interface mmc_out_if
    import mmc_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] corr_x;
    logic signed [OUT_W-1:0] corr_y;
    logic signed [OUT_W-1:0] corr_z;
    logic                    calibrated;
    logic                    span_fault;

    modport source (output valid, output corr_x, output corr_y, output corr_z,
                    output calibrated, output span_fault, input ready);
    modport sink (input valid, input corr_x, input corr_y, input corr_z,
                  input calibrated, input span_fault, output ready);
endinterface

@@ rtl/mmc_div.sv @@
module mmc_div
    import mmc_pkg::*;
#(
    parameter int NUM_W = 24,
    parameter int DEN_W = 12
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output div_stat_t        stat,
    output logic [NUM_W-1:0] quot
);
    localparam int CW = $clog2(NUM_W + 1);

    logic [DEN_W-1:0] den_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [CW-1:0]    cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DEN_W:0] trial;
    logic [DEN_W:0] diff;
    logic           take;

    // Restoring division, one quotient bit per cycle. The numerator shifts out
    // of the top of quo_reg while quotient bits shift in at the bottom.
    always_comb
    begin
        trial = {rem_reg, quo_reg[NUM_W-1]};
        take  = (trial >= {1'b0, den_reg});
        diff  = trial - {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= CW'(NUM_W);
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            den_reg <= den;
            rem_reg <= '0;
            quo_reg <= num;
        end
        else if (busy_reg)
        begin
            rem_reg <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            quo_reg <= {quo_reg[NUM_W-2:0], take};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quot      = quo_reg;

endmodule

@@ rtl/magnetometer_minmax_calibration.sv @@
// Min/max magnetometer calibration. A capture beat widens the per-axis
// extremes, a finalize beat freezes the center sums and divides the x span by
// the y and z spans into saturating scale ratios, using the one bit-per-cycle
// divider shared by both ratios, and a measure beat returns the corrected x,
// -y, -z in signed Q.4, using the single multiplier that serves the three axes
// in turn. One beat is worked on at a time; a finished result sits in an output
// register, so the next beat is taken while it waits to be read.
module magnetometer_minmax_calibration
    import mmc_pkg::*;
#(
    parameter int SAMPLE_BITS     = 13,
    parameter int RATIO_FRAC_BITS = 12
) (
    input  logic      clk,
    input  logic      rst_n,
    mmc_in_if.sink    smp,
    mmc_out_if.source res
);
    // Extremes must hold both the samples and the default values.
    localparam int EW        = (SAMPLE_BITS > 11) ? SAMPLE_BITS : 11;
    localparam int RW        = (RATIO_FRAC_BITS + 1 > 16) ? RATIO_FRAC_BITS + 1 : 16;
    localparam int DW        = EW + 3;
    localparam int PW        = DW + RW + 1;
    localparam int NUM_W     = EW + RATIO_FRAC_BITS;
    localparam int OUT_SHIFT = RATIO_FRAC_BITS - 3;

    state_t state_reg;
    state_t state_next;

    logic signed [EW-1:0]          min_reg [3];
    logic signed [EW-1:0]          max_reg [3];
    logic signed [EW:0]            sum_reg [3];
    logic [RW-1:0]                 ratio_y_reg;
    logic [RW-1:0]                 ratio_z_reg;
    logic                          fin_reg;
    logic                          flt_reg;
    logic                          bad_y_reg;

    logic signed [SAMPLE_BITS-1:0] h_reg [3];
    logic [1:0]                    ax_reg;
    logic signed [PW-1:0]          prod_reg;
    logic signed [OUT_W-1:0]       corr_reg [3];

    logic                          ov_reg;
    logic signed [OUT_W-1:0]       ox_reg;
    logic signed [OUT_W-1:0]       oy_reg;
    logic signed [OUT_W-1:0]       oz_reg;
    logic                          ocal_reg;
    logic                          oflt_reg;

    logic                          accept;
    logic                          out_free;

    logic signed [EW:0]            span_x;
    logic signed [EW:0]            span_y;
    logic signed [EW:0]            span_z;
    logic                          num_bad;
    logic                          bad_y;
    logic                          bad_z;

    logic                          div_start;
    logic [EW-1:0]                 div_den;
    logic [NUM_W-1:0]              div_num;
    logic [NUM_W-1:0]              div_quot;
    div_stat_t                     div_stat;
    logic [RW-1:0]                 div_ratio;

    logic signed [SAMPLE_BITS-1:0] h_sel;
    logic signed [EW:0]            sum_sel;
    logic [RW-1:0]                 r_sel;
    logic signed [DW-1:0]          d_mul;
    logic signed [RW:0]            r_mul;
    logic signed [PW-1:0]          sh;
    logic signed [PW-1:0]          sh_val;

    assign accept   = smp.valid && smp.ready;
    assign out_free = !ov_reg || res.ready;
    assign smp.ready = (state_reg == S_IDLE);

    // Spans from the live extremes; nothing changes them while dividing.
    always_comb
    begin
        span_x  = (EW+1)'(max_reg[0]) - (EW+1)'(min_reg[0]);
        span_y  = (EW+1)'(max_reg[1]) - (EW+1)'(min_reg[1]);
        span_z  = (EW+1)'(max_reg[2]) - (EW+1)'(min_reg[2]);
        num_bad = span_x[EW] || (span_x == '0);
        bad_y   = span_y[EW] || (span_y == '0);
        bad_z   = span_z[EW] || (span_z == '0);
    end

    assign div_start = (state_reg == S_FIN) || ((state_reg == S_DIVY) && div_stat.done);
    assign div_den   = (state_reg == S_FIN) ? span_y[EW-1:0] : span_z[EW-1:0];
    assign div_num   = {span_x[EW-1:0], {RATIO_FRAC_BITS{1'b0}}};

    mmc_div #(
        .NUM_W (NUM_W),
        .DEN_W (EW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .stat  (div_stat),
        .quot  (div_quot)
    );

    // Saturated ratio for the quotient that just finished; the bad flag is
    // taken from the span the divider was working on.
    function automatic logic [RW-1:0] make_ratio(input logic [NUM_W-1:0] q,
                                                 input logic den_bad,
                                                 input logic nbad);
        logic [RW-1:0] r;
        if (den_bad)
            r = RW'(RATIO_MAX);
        else if (nbad)
            r = '0;
        else if (|q[NUM_W-1:16])
            r = RW'(RATIO_MAX);
        else
            r = RW'(q[15:0]);
        return r;
    endfunction

    always_comb
    begin
        if (state_reg == S_DIVY)
            div_ratio = make_ratio(div_quot, bad_y, num_bad);
        else
            div_ratio = make_ratio(div_quot, bad_z, num_bad);
    end

    // Operands of the shared multiplier for the current axis.
    always_comb
    begin
        case (ax_reg)
            AXIS_X:
            begin
                h_sel   = h_reg[0];
                sum_sel = sum_reg[0];
                r_sel   = RW'(2 ** RATIO_FRAC_BITS);
            end
            AXIS_Y:
            begin
                h_sel   = h_reg[1];
                sum_sel = sum_reg[1];
                r_sel   = ratio_y_reg;
            end
            default:
            begin
                h_sel   = h_reg[2];
                sum_sel = sum_reg[2];
                r_sel   = ratio_z_reg;
            end
        endcase
        d_mul  = (DW'(h_sel) <<< 1) - DW'(sum_sel);
        r_mul  = $signed({1'b0, r_sel});
        // An arithmetic shift of a signed value rounds toward minus infinity.
        sh     = prod_reg >>> OUT_SHIFT;
        sh_val = (ax_reg == AXIS_X) ? sh : -sh;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (smp.kind)
                        KIND_CAPTURE:  state_next = S_CAPT;
                        KIND_FINALIZE: state_next = S_FIN;
                        KIND_MEASURE:  state_next = S_MUL;
                        default:       state_next = S_WB;
                    endcase
                end
            end
            S_CAPT: state_next = S_WB;
            S_FIN:  state_next = S_DIVY;
            S_DIVY:
            begin
                if (div_stat.done)
                    state_next = S_DIVZ;
            end
            S_DIVZ:
            begin
                if (div_stat.done)
                    state_next = S_WB;
            end
            S_MUL:  state_next = S_ACC;
            S_ACC:  state_next = (ax_reg == AXIS_Z) ? S_WB : S_MUL;
            S_WB:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            min_reg[0]  <= EW'(XMIN_DEF);
            max_reg[0]  <= EW'(XMAX_DEF);
            min_reg[1]  <= EW'(YMIN_DEF);
            max_reg[1]  <= EW'(YMAX_DEF);
            min_reg[2]  <= EW'(ZMIN_DEF);
            max_reg[2]  <= EW'(ZMAX_DEF);
            sum_reg[0]  <= '0;
            sum_reg[1]  <= '0;
            sum_reg[2]  <= '0;
            ratio_y_reg <= RW'(2 ** RATIO_FRAC_BITS);
            ratio_z_reg <= RW'(2 ** RATIO_FRAC_BITS);
            fin_reg     <= 1'b0;
            flt_reg     <= 1'b0;
            ov_reg      <= 1'b0;
            ax_reg      <= AXIS_X;
        end
        else
        begin
            state_reg <= state_next;

            if (state_reg == S_CAPT)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (EW'(h_reg[i]) < min_reg[i])
                        min_reg[i] <= EW'(h_reg[i]);
                    if (EW'(h_reg[i]) > max_reg[i])
                        max_reg[i] <= EW'(h_reg[i]);
                end
            end

            if (state_reg == S_FIN)
            begin
                for (int i = 0; i < 3; i++)
                    sum_reg[i] <= (EW+1)'(min_reg[i]) + (EW+1)'(max_reg[i]);
            end

            if ((state_reg == S_DIVY) && div_stat.done)
                ratio_y_reg <= div_ratio;

            if ((state_reg == S_DIVZ) && div_stat.done)
            begin
                ratio_z_reg <= div_ratio;
                flt_reg     <= bad_y_reg || bad_z;
                fin_reg     <= 1'b1;
            end

            if (accept)
                ax_reg <= AXIS_X;
            else if (state_reg == S_ACC)
                ax_reg <= ax_reg + 1'b1;

            if ((state_reg == S_WB) && out_free)
                ov_reg <= 1'b1;
            else if (res.ready)
                ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            h_reg[0]    <= smp.axis_x;
            h_reg[1]    <= smp.axis_y;
            h_reg[2]    <= smp.axis_z;
            corr_reg[0] <= '0;
            corr_reg[1] <= '0;
            corr_reg[2] <= '0;
        end
        else if (state_reg == S_ACC)
        begin
            corr_reg[ax_reg] <= sh_val[OUT_W-1:0];
        end

        if (state_reg == S_FIN)
            bad_y_reg <= bad_y;

        if (state_reg == S_MUL)
            prod_reg <= d_mul * r_mul;

        if ((state_reg == S_WB) && out_free)
        begin
            ox_reg   <= corr_reg[0];
            oy_reg   <= corr_reg[1];
            oz_reg   <= corr_reg[2];
            ocal_reg <= fin_reg;
            oflt_reg <= flt_reg;
        end
    end

    assign res.valid      = ov_reg;
    assign res.corr_x     = ox_reg;
    assign res.corr_y     = oy_reg;
    assign res.corr_z     = oz_reg;
    assign res.calibrated = ocal_reg;
    assign res.span_fault = oflt_reg;

    // The divider only runs while the sequencer waits on a ratio.
    a_div_owned: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.busy |-> (state_reg == S_DIVY || state_reg == S_DIVZ))
        else $error("divider busy outside a ratio step");

    // A span fault always leaves at least one saturated ratio behind.
    a_fault_ratio: assert property (@(posedge clk) disable iff (!rst_n)
        flt_reg |-> (ratio_y_reg == RW'(RATIO_MAX) || ratio_z_reg == RW'(RATIO_MAX)))
        else $error("span fault without a saturated ratio");

    // Finishing the second ratio marks the block calibrated.
    a_fin_set: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIVZ && div_stat.done) |=> fin_reg)
        else $error("finalize did not set calibrated");

    // A new result appears only out of the write-back step.
    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ov_reg) |-> $past(state_reg == S_WB))
        else $error("result valid raised outside write-back");

endmodule
